// ----- design/atca_pkg.sv -----
// atca_pkg: shared types and constants of the affine transform block
// no dependencies
`default_nettype none
package atca_pkg;
  localparam int WORK_BITS = 30;
  localparam logic signed [33:0] GAIN_Q30 = 34'sd652032874;
  localparam logic signed [33:0] PI_Q30 = 34'sd3373259426;
  localparam logic signed [33:0] HALF_PI_Q30 = 34'sd1686629713;

  typedef enum logic [2:0] {
    FN_IDENT = 3'd0, FN_ROT_CW = 3'd1, FN_ROT_CCW = 3'd2,
    FN_REFLECT = 3'd3, FN_TRANS = 3'd4, FN_POINT = 3'd5,
    FN_RSV6 = 3'd6, FN_RSV7 = 3'd7
  } func_t;

  // datapath operation codes
  typedef enum logic [3:0] {
    OP_NONE, OP_IDENT, OP_CORDIC_INIT, OP_CORDIC_STEP, OP_CORDIC_FIN,
    OP_REFL_MUL, OP_REFL_FIN, OP_LOAD_ROT, OP_LOAD_TRANS, OP_MAC,
    OP_COMMIT, OP_POINT_MAC
  } op_t;

  typedef struct packed {
    op_t        op;
    logic       first;   // first product of a pair
    logic [2:0] sel;     // entry index or product select
    logic [4:0] iter;
  } cmd_t;

  function automatic logic signed [33:0] atan_q30(input logic [4:0] i);
    case (i)
      5'd0: atan_q30 = 34'sd843314857;  5'd1: atan_q30 = 34'sd497837829;
      5'd2: atan_q30 = 34'sd263043837;  5'd3: atan_q30 = 34'sd133525159;
      5'd4: atan_q30 = 34'sd67021687;   5'd5: atan_q30 = 34'sd33543516;
      5'd6: atan_q30 = 34'sd16775851;   5'd7: atan_q30 = 34'sd8388437;
      5'd8: atan_q30 = 34'sd4194283;    5'd9: atan_q30 = 34'sd2097149;
      5'd10: atan_q30 = 34'sd1048576;   5'd11: atan_q30 = 34'sd524288;
      5'd12: atan_q30 = 34'sd262144;    5'd13: atan_q30 = 34'sd131072;
      5'd14: atan_q30 = 34'sd65536;     5'd15: atan_q30 = 34'sd32768;
      5'd16: atan_q30 = 34'sd16384;     5'd17: atan_q30 = 34'sd8192;
      5'd18: atan_q30 = 34'sd4096;      5'd19: atan_q30 = 34'sd2048;
      5'd20: atan_q30 = 34'sd1024;      5'd21: atan_q30 = 34'sd512;
      5'd22: atan_q30 = 34'sd256;       5'd23: atan_q30 = 34'sd128;
      default: atan_q30 = 34'sd0;
    endcase
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
    if (v > 66'sd2147483647) sat32 = 32'sh7fffffff;
    else if (v < -66'sd2147483648) sat32 = 32'sh80000000;
    else sat32 = v[31:0];
  endfunction
endpackage
`default_nettype wire

// ----- design/atca_if.sv -----
// atca_if: valid/ready channel interfaces for items in and results out
// depends on nothing
`default_nettype none
interface atca_in_if;
  logic               valid;
  logic               ready;
  logic [2:0]         func;
  logic signed [15:0] angle;
  logic signed [31:0] x_in;
  logic signed [31:0] y_in;
  modport source(output valid, func, angle, x_in, y_in, input ready);
  modport sink(input valid, func, angle, x_in, y_in, output ready);
endinterface

interface atca_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] x_out;
  logic signed [31:0] y_out;
  modport source(output valid, x_out, y_out, input ready);
  modport sink(input valid, x_out, y_out, output ready);
endinterface
`default_nettype wire

// ----- design/atca_datapath.sv -----
// atca_datapath: matrix store, CORDIC unit and one shared multiplier
// depends on atca_pkg
`default_nettype none
module atca_datapath
  import atca_pkg::*;
#(
  parameter int FRACTION_BITS = 16
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire cmd_t               cmd,
  input  wire logic               load,
  input  wire logic signed [15:0] angle,
  input  wire logic signed [31:0] x_in,
  input  wire logic signed [31:0] y_in,
  output logic signed [31:0]      x_res,
  output logic signed [31:0]      y_res
);
  logic signed [31:0] m_r [6];
  logic signed [31:0] r_r [6];
  logic signed [33:0] cx_r, cy_r, cz_r;
  logic               neg_r;
  logic signed [33:0] f_r [4];
  logic signed [31:0] xi_r, yi_r;
  logic signed [15:0] ang_r;
  logic signed [65:0] p_r, acc_r;
  logic signed [33:0] ma;
  logic signed [33:0] mb;
  logic signed [67:0] prod;
  logic signed [33:0] z0;
  logic signed [33:0] dx, dy;
  logic               row;
  logic [1:0]         col;
  logic [2:0]         rbase;
  logic signed [65:0] sum_h, rnd;
  logic signed [65:0] tv;
  logic [4:0]         it;

  assign it = cmd.iter;
  assign row = (cmd.sel >= 3'd3);
  assign col = (cmd.sel >= 3'd3) ? 2'(cmd.sel - 3'd3) : cmd.sel[1:0];
  assign rbase = row ? 3'd3 : 3'd0;
  assign z0 = 34'(ang_r) <<< (WORK_BITS - 13);
  assign dx = cy_r >>> it;
  assign dy = cx_r >>> it;

  // operand select for the shared multiplier
  always_comb begin
    ma = '0;
    mb = '0;
    case (cmd.op)
      OP_REFL_MUL: begin
        case (cmd.sel)
          3'd0: begin ma = cx_r; mb = cx_r; end
          3'd1: begin ma = cy_r; mb = cy_r; end
          default: begin ma = cx_r; mb = cy_r; end
        endcase
      end
      OP_MAC: begin
        ma = cmd.first ? f_r[{row, 1'b0}] : f_r[{row, 1'b1}];
        mb = cmd.first ? 34'(m_r[{1'b0, col}]) : 34'(m_r[3'd3 + {1'b0, col}]);
      end
      OP_POINT_MAC: begin
        ma = 34'(m_r[rbase + (cmd.first ? 3'd0 : 3'd1)]);
        mb = cmd.first ? 34'(xi_r) : 34'(yi_r);
      end
      default: ;
    endcase
  end
  assign prod = ma * mb;

  // half sum keeps the pair sum in range, then round half up
  always_comb begin
    sum_h = (p_r >>> 1) + (66'(prod) >>> 1) + $signed({65'd0, p_r[0] & prod[0]});
    if (cmd.op == OP_POINT_MAC)
      rnd = (sum_h + (66'sd1 <<< (FRACTION_BITS - 2))) >>> (FRACTION_BITS - 1);
    else
      rnd = (sum_h + (66'sd1 <<< (WORK_BITS - 2))) >>> (WORK_BITS - 1);
  end
  always_comb begin
    tv = rnd;
    if (cmd.op == OP_POINT_MAC)
      tv = rnd + 66'(m_r[rbase + 3'd2]);
    else if (cmd.op == OP_MAC && col == 2'd2)
      tv = rnd + (row ? 66'(yi_r) : 66'(xi_r));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m_r[0] <= 32'(1) <<< FRACTION_BITS; m_r[1] <= '0; m_r[2] <= '0;
      m_r[3] <= '0; m_r[4] <= 32'(1) <<< FRACTION_BITS; m_r[5] <= '0;
    end else begin
      if (load) begin
        ang_r <= angle;
        xi_r  <= x_in;
        yi_r  <= y_in;
      end
      case (cmd.op)
        OP_IDENT: begin
          m_r[0] <= 32'(1) <<< FRACTION_BITS; m_r[1] <= '0; m_r[2] <= '0;
          m_r[3] <= '0; m_r[4] <= 32'(1) <<< FRACTION_BITS; m_r[5] <= '0;
        end
        OP_CORDIC_INIT: begin
          cx_r <= GAIN_Q30;
          cy_r <= '0;
          if (z0 > HALF_PI_Q30) begin
            cz_r <= z0 - PI_Q30; neg_r <= 1'b1;
          end else if (z0 < -HALF_PI_Q30) begin
            cz_r <= z0 + PI_Q30; neg_r <= 1'b1;
          end else begin
            cz_r <= z0; neg_r <= 1'b0;
          end
        end
        OP_CORDIC_STEP: begin
          if (!cz_r[33]) begin
            cx_r <= cx_r - dx; cy_r <= cy_r + dy; cz_r <= cz_r - atan_q30(it);
          end else begin
            cx_r <= cx_r + dx; cy_r <= cy_r - dy; cz_r <= cz_r + atan_q30(it);
          end
        end
        OP_CORDIC_FIN: begin
          if (neg_r) begin cx_r <= -cx_r; cy_r <= -cy_r; end
        end
        OP_REFL_MUL: begin
          case (cmd.sel)
            3'd0: acc_r <= prod[65:0];
            3'd1: acc_r <= acc_r - prod[65:0];
            default: p_r <= prod[65:0];
          endcase
        end
        OP_REFL_FIN: begin
          f_r[0] <= 34'((acc_r + (66'sd1 <<< (WORK_BITS - 1))) >>> WORK_BITS);
          f_r[3] <= -34'((acc_r + (66'sd1 <<< (WORK_BITS - 1))) >>> WORK_BITS);
          f_r[1] <= 34'(((p_r <<< 1) + (66'sd1 <<< (WORK_BITS - 1))) >>> WORK_BITS);
          f_r[2] <= 34'(((p_r <<< 1) + (66'sd1 <<< (WORK_BITS - 1))) >>> WORK_BITS);
          xi_r <= '0; yi_r <= '0;
        end
        OP_LOAD_ROT: begin
          f_r[0] <= cx_r; f_r[3] <= cx_r;
          f_r[1] <= cmd.first ? cy_r : -cy_r;
          f_r[2] <= cmd.first ? -cy_r : cy_r;
          xi_r <= '0; yi_r <= '0;
        end
        OP_LOAD_TRANS: begin
          f_r[0] <= 34'sd1 <<< WORK_BITS; f_r[3] <= 34'sd1 <<< WORK_BITS;
          f_r[1] <= '0; f_r[2] <= '0;
        end
        OP_MAC, OP_POINT_MAC: begin
          if (cmd.first) p_r <= prod[65:0];
          else if (cmd.op == OP_MAC) r_r[cmd.sel] <= sat32(tv);
          else if (row) y_res <= sat32(tv);
          else x_res <= sat32(tv);
        end
        OP_COMMIT: begin
          for (int k = 0; k < 6; k++) m_r[k] <= r_r[k];
        end
        default: ;
      endcase
    end
  end
endmodule
`default_nettype wire

// ----- design/atca_ctrl.sv -----
// atca_ctrl: sequencer that issues datapath commands for each item
// depends on atca_pkg
`default_nettype none
module atca_ctrl
  import atca_pkg::*;
#(
  parameter int CORDIC_ITERATIONS = 16
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  input  wire logic [2:0] in_func,
  output logic            in_ready,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic            load,
  output cmd_t            cmd
);
  localparam int NIT = (CORDIC_ITERATIONS > 24) ? 24 : CORDIC_ITERATIONS;
  typedef enum logic [3:0] {
    S_IDLE, S_EXEC, S_CINIT, S_CSTEP, S_CFIN, S_REFL, S_RFIN, S_LOAD,
    S_MAC, S_COMMIT, S_PMAC, S_OUT
  } state_t;
  state_t     state_r;
  func_t      func_r;
  logic [4:0] cnt_r;
  logic       half_r;

  assign in_ready = (state_r == S_IDLE);
  assign out_valid = (state_r == S_OUT);
  assign load = in_valid && in_ready;

  always_comb begin
    cmd = '{op: OP_NONE, first: half_r == 1'b0, sel: cnt_r[2:0], iter: cnt_r};
    case (state_r)
      S_EXEC:   cmd.op = (func_r == FN_IDENT) ? OP_IDENT : OP_NONE;
      S_CINIT:  cmd.op = OP_CORDIC_INIT;
      S_CSTEP:  cmd.op = OP_CORDIC_STEP;
      S_CFIN:   cmd.op = OP_CORDIC_FIN;
      S_REFL:   cmd.op = OP_REFL_MUL;
      S_RFIN:   cmd.op = OP_REFL_FIN;
      S_LOAD: begin
        cmd.op = (func_r == FN_TRANS) ? OP_LOAD_TRANS : OP_LOAD_ROT;
        cmd.first = (func_r == FN_ROT_CW);
      end
      S_MAC:    cmd.op = OP_MAC;
      S_COMMIT: cmd.op = OP_COMMIT;
      S_PMAC: begin
        cmd.op = OP_POINT_MAC;
        cmd.sel = cnt_r[0] ? 3'd3 : 3'd0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r <= '0;
      half_r <= 1'b0;
      func_r <= FN_IDENT;
    end else begin
      case (state_r)
        S_IDLE: if (in_valid) begin
          func_r <= func_t'(in_func);
          state_r <= S_EXEC;
        end
        S_EXEC: begin
          cnt_r <= '0;
          half_r <= 1'b0;
          case (func_r)
            FN_ROT_CW, FN_ROT_CCW, FN_REFLECT: state_r <= S_CINIT;
            FN_TRANS: state_r <= S_LOAD;
            FN_POINT: state_r <= S_PMAC;
            default: state_r <= S_IDLE;
          endcase
        end
        S_CINIT: state_r <= S_CSTEP;
        S_CSTEP: begin
          cnt_r <= cnt_r + 5'd1;
          if (cnt_r == 5'(NIT - 1)) state_r <= S_CFIN;
        end
        S_CFIN: begin
          cnt_r <= '0;
          state_r <= (func_r == FN_REFLECT) ? S_REFL : S_LOAD;
        end
        S_REFL: begin
          cnt_r <= cnt_r + 5'd1;
          if (cnt_r == 5'd2) state_r <= S_RFIN;
        end
        S_RFIN: begin cnt_r <= '0; state_r <= S_MAC; end
        S_LOAD: begin cnt_r <= '0; state_r <= S_MAC; end
        S_MAC: begin
          half_r <= ~half_r;
          if (half_r) begin
            cnt_r <= cnt_r + 5'd1;
            if (cnt_r == 5'd5) state_r <= S_COMMIT;
          end
        end
        S_COMMIT: state_r <= S_IDLE;
        S_PMAC: begin
          half_r <= ~half_r;
          if (half_r) begin
            cnt_r <= cnt_r + 5'd1;
            if (cnt_r == 5'd1) state_r <= S_OUT;
          end
        end
        S_OUT: if (out_ready) state_r <= S_IDLE;
        default: state_r <= S_IDLE;
      endcase
    end
  end

  a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !in_ready) else $error("ready while result pending");
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid) else $error("result dropped");
  a_accept_exec: assert property (@(posedge clk) disable iff (!rst_n)
    load |=> state_r == S_EXEC) else $error("item not started");
endmodule
`default_nettype wire

// ----- design/affine_transform_compose_apply.sv -----
// affine_transform_compose_apply: 2x3 affine transform, compose and map point
// one item at a time; the CORDIC steps and the single shared multiplier set how long an item takes
// reset (synchronous, active low) loads the identity transform
`default_nettype none
module affine_transform_compose_apply
  import atca_pkg::*;
#(
  parameter int CORDIC_ITERATIONS = 16,
  parameter int FRACTION_BITS = 16
) (
  input wire logic clk,
  input wire logic rst_n,
  atca_in_if.sink  in_ch,
  atca_out_if.source out_ch
);
  cmd_t cmd;
  logic load;

  atca_ctrl #(.CORDIC_ITERATIONS(CORDIC_ITERATIONS)) u_ctrl (
    .clk, .rst_n, .in_valid(in_ch.valid), .in_func(in_ch.func),
    .in_ready(in_ch.ready), .out_valid(out_ch.valid), .out_ready(out_ch.ready),
    .load, .cmd
  );

  atca_datapath #(
    .FRACTION_BITS(FRACTION_BITS)
  ) u_dp (
    .clk, .rst_n, .cmd, .load, .angle(in_ch.angle), .x_in(in_ch.x_in),
    .y_in(in_ch.y_in), .x_res(out_ch.x_out), .y_res(out_ch.y_out)
  );
endmodule
`default_nettype wire

// ----- verif/affine_transform_compose_apply_test.sv -----
// testbench for affine_transform_compose_apply: directed and random items, scoreboard check
// depends on atca_pkg, atca_in_if, atca_out_if and affine_transform_compose_apply from the design folder
`timescale 1ns / 100ps

module affine_transform_compose_apply_test;
  import atca_pkg::*;

  localparam int ITERS = 16;
  localparam int FBITS = 16;
  localparam int RANDOM_ITEMS = 1800;

  // affine state tracker with a queue of mapped points still due
  class affine_scoreboard;
    longint mat[6];
    logic [31:0] due_x[$];
    logic [31:0] due_y[$];
    int errors;
    int points_seen;
    longint atan_tab[24] = '{
      843314857, 497837829, 263043837, 133525159, 67021687,
      33543516, 16775851, 8388437, 4194283, 2097149, 1048576,
      524288, 262144, 131072, 65536, 32768, 16384, 8192,
      4096, 2048, 1024, 512, 256, 128};

    function new();
      errors = 0;
      points_seen = 0;
      load_identity();
    endfunction

    function void load_identity();
      foreach (mat[i]) mat[i] = 0;
      mat[0] = longint'(1) << FBITS;
      mat[4] = longint'(1) << FBITS;
    endfunction

    function longint clamp32(longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
    endfunction

    // (p + q) / 2^s rounded half up, no overflow of the sum
    function longint rnd_pair(longint p, longint q, int s);
      longint h;
      h = (p >>> 1) + (q >>> 1) + ((p & 1) & (q & 1));
      return (h + (longint'(1) << (s - 2))) >>> (s - 1);
    endfunction

    function void cos_sin(longint ang, output longint c, output longint s);
      longint z, x, y, dx, dy;
      bit neg;
      z = ang * (longint'(1) << (WORK_BITS - 13));
      x = GAIN_Q30;
      y = 0;
      neg = 0;
      if (z > HALF_PI_Q30) begin
        z -= PI_Q30;
        neg = 1;
      end else if (z < -HALF_PI_Q30) begin
        z += PI_Q30;
        neg = 1;
      end
      for (int i = 0; i < ITERS; i++) begin
        dx = y >>> i;
        dy = x >>> i;
        if (z >= 0) begin
          x -= dx; y += dy; z -= atan_tab[i];
        end else begin
          x += dx; y -= dy; z += atan_tab[i];
        end
      end
      c = neg ? -x : x;
      s = neg ? -y : y;
    endfunction

    function void premultiply(longint f0, longint f1, longint f2, longint f3,
                              longint tx, longint ty);
      longint r[6];
      longint fa, fb, v;
      for (int row = 0; row < 2; row++) begin
        fa = row == 0 ? f0 : f2;
        fb = row == 0 ? f1 : f3;
        for (int col = 0; col < 3; col++) begin
          v = rnd_pair(fa * mat[col], fb * mat[3 + col], WORK_BITS);
          if (col == 2) v += row == 0 ? tx : ty;
          r[row * 3 + col] = clamp32(v);
        end
      end
      mat = r;
    endfunction

    function void note_input(logic [2:0] fn, logic [15:0] angle,
                             logic [31:0] xi, logic [31:0] yi);
      longint ang, xv, yv, c, s, a, b, one;
      ang = longint'($signed(angle));
      xv = longint'($signed(xi));
      yv = longint'($signed(yi));
      one = longint'(1) << WORK_BITS;
      case (fn)
        FN_IDENT: load_identity();
        FN_ROT_CW: begin
          cos_sin(ang, c, s);
          premultiply(c, s, -s, c, 0, 0);
        end
        FN_ROT_CCW: begin
          cos_sin(ang, c, s);
          premultiply(c, -s, s, c, 0, 0);
        end
        FN_REFLECT: begin
          cos_sin(ang, c, s);
          a = (c * c - s * s + (one >>> 1)) >>> WORK_BITS;
          b = (2 * c * s + (one >>> 1)) >>> WORK_BITS;
          premultiply(a, b, b, -a, 0, 0);
        end
        FN_TRANS: premultiply(one, 0, 0, one, xv, yv);
        FN_POINT: begin
          due_x.push_back(32'(clamp32(rnd_pair(mat[0] * xv, mat[1] * yv, FBITS) + mat[2])));
          due_y.push_back(32'(clamp32(rnd_pair(mat[3] * xv, mat[4] * yv, FBITS) + mat[5])));
        end
        default: ;
      endcase
    endfunction

    task report(string msg);
      $display("mismatch at %0t: %s", $realtime, msg);
      errors++;
    endtask

    task check_result(logic [31:0] xo, logic [31:0] yo);
      logic [31:0] ex, ey;
      points_seen++;
      if (due_x.size() == 0) begin
        report($sformatf("unexpected point %h %h", xo, yo));
      end else begin
        ex = due_x.pop_front();
        ey = due_y.pop_front();
        if (xo !== ex) report($sformatf("x_out %h, want %h", xo, ex));
        if (yo !== ey) report($sformatf("y_out %h, want %h", yo, ey));
      end
    endtask

    function int pending();
      return due_x.size();
    endfunction
  endclass

  logic clk = 0;
  logic rst_n = 0;
  atca_in_if in_ch();
  atca_out_if out_ch();
  affine_scoreboard board = new();
  bit hold_req = 0;
  int hold_cnt = 0;
  int rx_cyc = 0;
  int items_sent = 0;

  affine_transform_compose_apply i_dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch));

  always #2 clk = ~clk;

  initial begin
    in_ch.valid = 0;
    in_ch.func = '0;
    in_ch.angle = '0;
    in_ch.x_in = '0;
    in_ch.y_in = '0;
    out_ch.ready = 0;
  end

  // receiver: stall pattern, plus one long hold-off on request
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) board.check_result(out_ch.x_out, out_ch.y_out);
    rx_cyc++;
    if (hold_req && hold_cnt == 0) begin
      hold_cnt = 800;
      hold_req = 0;
    end
    if (hold_cnt > 0) begin
      hold_cnt--;
      out_ch.ready <= 1'b0;
    end else if ((rx_cyc % 300) < 100) begin
      out_ch.ready <= 1'b1;
    end else begin
      out_ch.ready <= ($urandom_range(0, 3) != 0);
    end
  end

  int burst_left = 0;

  task send_item(func_t fn, logic [15:0] angle, logic [31:0] xi, logic [31:0] yi);
    int gap;
    in_ch.valid <= 1'b1;
    in_ch.func <= fn;
    in_ch.angle <= angle;
    in_ch.x_in <= xi;
    in_ch.y_in <= yi;
    do @(posedge clk); while (!in_ch.ready);
    board.note_input(fn, angle, xi, yi);
    items_sent++;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(0, 12);
      gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 60);
      if (gap > 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  function logic [31:0] pick_coord();
    case ($urandom_range(0, 3))
      0: return $urandom();
      1: return 32'($signed($urandom_range(0, 32'h000fffff)) - 32'sh00080000);
      2: return $urandom_range(0, 1) ? 32'h7fffffff : 32'h80000000;
      default: return 32'($signed($urandom_range(0, 32'h03ffffff)) - 32'sh02000000);
    endcase
  endfunction

  initial begin
    func_t fn;
    logic [31:0] xs, ys;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // identity after reset, extremes of the point range
    send_item(FN_POINT, 16'h0000, 32'h7fffffff, 32'h80000000);
    send_item(FN_POINT, 16'hffff, 32'h80000000, 32'h7fffffff);
    send_item(FN_POINT, 16'h0000, 32'h00010000, 32'hffff0000);
    // rotations at zero, near plus and minus pi/2, and the angle extremes
    send_item(FN_ROT_CW, 16'h0000, 32'h0, 32'h0);
    send_item(FN_ROT_CW, 16'd12868, 32'h0, 32'h0);
    send_item(FN_ROT_CCW, 16'd12869, 32'h0, 32'h0);
    send_item(FN_POINT, 16'h0, 32'h00030000, 32'h00050000);
    send_item(FN_ROT_CCW, 16'h7fff, 32'hffffffff, 32'hffffffff);
    send_item(FN_ROT_CW, 16'h8000, 32'h0, 32'h0);
    send_item(FN_ROT_CCW, -16'sd12869, 32'h0, 32'h0);
    send_item(FN_POINT, 16'h0, 32'h12345678, 32'hfedcba98);
    // reflection, translation with saturating shifts
    send_item(FN_REFLECT, 16'h1234, 32'h0, 32'h0);
    send_item(FN_REFLECT, 16'h8000, 32'h0, 32'h0);
    send_item(FN_TRANS, 16'h0, 32'h7fffffff, 32'h80000000);
    send_item(FN_TRANS, 16'h0, 32'h7fffffff, 32'h80000000);
    send_item(FN_POINT, 16'h0, 32'h7fffffff, 32'h7fffffff);
    // reserved codes leave the transform alone
    send_item(FN_RSV6, 16'hffff, 32'hffffffff, 32'hffffffff);
    send_item(FN_RSV7, 16'h5555, 32'haaaaaaaa, 32'h55555555);
    send_item(FN_POINT, 16'h0, 32'h0, 32'h0);
    send_item(FN_IDENT, 16'hffff, 32'hffffffff, 32'hffffffff);
    send_item(FN_POINT, 16'h0, 32'h00008000, 32'hffff8000);

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n == 600) hold_req = 1;
      case ($urandom_range(0, 19))
        0: fn = FN_IDENT;
        1, 2, 3: fn = FN_ROT_CW;
        4, 5, 6: fn = FN_ROT_CCW;
        7, 8: fn = FN_REFLECT;
        9, 10, 11: fn = FN_TRANS;
        12: fn = func_t'($urandom_range(6, 7));
        default: fn = FN_POINT;
      endcase
      xs = pick_coord();
      ys = pick_coord();
      if (fn == FN_TRANS && $urandom_range(0, 3) != 0) begin
        xs = 32'($signed($urandom_range(0, 32'h001fffff)) - 32'sh00100000);
        ys = 32'($signed($urandom_range(0, 32'h001fffff)) - 32'sh00100000);
      end
      send_item(fn, 16'($urandom()), xs, ys);
    end
    in_ch.valid <= 1'b0;

    while (board.pending() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    $display("%0d items sent, %0d points mapped and checked, incl. a long output stall",
             items_sent, board.points_seen);
    if (board.errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  initial begin
    #8000000;
    $display("timeout with %0d points outstanding", board.pending());
    $display("[FAIL] regression broken");
    $finish;
  end
endmodule
